// ===== design/glc_pkg.sv =====
// ---------------------------------------------------------------------------
// glc_pkg - shared types and constants for the graph local complement block
// Command format between front end and execution unit, opcode and state codes.
// ---------------------------------------------------------------------------
package glc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int ROW_W        = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 6;
    localparam int OP_W         = 2;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(MAX_VERTICES);

    localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLEMENT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ       = 2'd2;

    typedef enum logic [1:0] {
        OPC_WRITE,
        OPC_COMPLEMENT,
        OPC_READ,
        OPC_ERROR
    } op_class_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FETCH,
        BS_SCAN,
        BS_DRAIN,
        BS_EMIT
    } back_state_t;

    typedef struct packed {
        op_class_t          op;
        logic [VIDX_W-1:0]  vertex;
        logic [ROW_W-1:0]   row_bits;
        logic               color;
        logic [ROW_W-1:0]   nbr_mask;   // in-range vertices, pivot excluded
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/glc_front.sv =====
// ---------------------------------------------------------------------------
// glc_front - input acceptance and command classification
// Holds the vertex count, range-checks the vertex and builds the command.
// ---------------------------------------------------------------------------
module glc_front
    import glc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [VIDX_W-1:0]   vertex,
    input  logic [ROW_W-1:0]    row_bits,
    input  logic                color_in,
    input  q_status_t           q_status,
    output logic                push,
    output cmd_t                cmd
);

    logic [CNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0] lim;
    logic [ROW_W-1:0] lim_mask;
    logic             in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vcount_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        lim = (vcount_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_reg;
        if (lim >= CNT_W'(ROW_W))
        begin
            lim_mask = '1;
        end
        else
        begin
            lim_mask = (ROW_W'(1) << lim) - ROW_W'(1);
        end
        in_range = {1'b0, vertex} < lim;

        cmd.vertex   = vertex;
        cmd.row_bits = row_bits;
        cmd.color    = color_in;
        cmd.nbr_mask = lim_mask & ~(ROW_W'(1) << vertex);
        if (!in_range)
        begin
            cmd.op = OPC_ERROR;
        end
        else
        begin
            case (operation)
                OP_WRITE:      cmd.op = OPC_WRITE;
                OP_COMPLEMENT: cmd.op = OPC_COMPLEMENT;
                default:       cmd.op = OPC_READ;     // code three reads too
            endcase
        end
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

// ===== design/glc_queue.sv =====
// ---------------------------------------------------------------------------
// glc_queue - short command FIFO between front end and execution unit
// ---------------------------------------------------------------------------
module glc_queue
    import glc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_data,
    input  logic        pop,
    output cmd_t        pop_data,
    output q_status_t   q_status
);

    cmd_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/glc_back.sv =====
// ---------------------------------------------------------------------------
// glc_back - execution unit
// Owns the adjacency row memory and colour bits, runs write, read and the
// neighbour scan of a complement, and drives the output register.
// ---------------------------------------------------------------------------
module glc_back
    import glc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_status_t           q_status,
    input  cmd_t                q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ROW_W-1:0]    row_out,
    output logic                color_out,
    output logic                status
);

    // adjacency rows: one write port, one registered read port
    logic [ROW_W-1:0]           mem [MAX_VERTICES];
    logic [ROW_W-1:0]           rd_data_reg;
    logic                       mem_we;
    logic [VIDX_W-1:0]          mem_waddr;
    logic [ROW_W-1:0]           mem_wdata;
    logic [VIDX_W-1:0]          mem_raddr;

    back_state_t                state_reg, state_next;
    cmd_t                       cmd_reg, cmd_next;
    logic [ROW_W-1:0]           nbr_reg, nbr_next;
    logic [VIDX_W-1:0]          scan_reg, scan_next;
    logic                       pend_reg, pend_next;
    logic [VIDX_W-1:0]          pend_addr_reg, pend_addr_next;
    logic [MAX_VERTICES-1:0]    colors_reg, colors_next;
    logic [ROW_W-1:0]           res_row_reg, res_row_next;
    logic                       res_color_reg, res_color_next;
    logic                       res_status_reg, res_status_next;
    logic                       out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]           row_out_reg, row_out_next;
    logic                       color_out_reg, color_out_next;
    logic                       status_reg, status_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            pend_reg      <= 1'b0;
            colors_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            colors_reg    <= colors_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        nbr_reg        <= nbr_next;
        scan_reg       <= scan_next;
        pend_addr_reg  <= pend_addr_next;
        res_row_reg    <= res_row_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        row_out_reg    <= row_out_next;
        color_out_reg  <= color_out_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        nbr_next        = nbr_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        colors_next     = colors_reg;
        res_row_next    = res_row_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        row_out_next    = row_out_reg;
        color_out_next  = color_out_reg;
        status_next     = status_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = rd_data_reg ^ (nbr_reg & ~(ROW_W'(1) << pend_addr_reg));
        mem_raddr       = scan_reg;

        case (state_reg)
            BS_IDLE:
            begin
                mem_raddr = q_data.vertex;
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_data;
                    case (q_data.op)
                        OPC_WRITE:
                        begin
                            mem_we                     = 1'b1;
                            mem_waddr                  = q_data.vertex;
                            mem_wdata                  = q_data.row_bits;
                            colors_next[q_data.vertex] = q_data.color;
                            res_row_next               = q_data.row_bits;
                            res_color_next             = q_data.color;
                            res_status_next            = 1'b0;
                            state_next                 = BS_EMIT;
                        end
                        OPC_ERROR:
                        begin
                            res_row_next    = '0;
                            res_color_next  = 1'b0;
                            res_status_next = 1'b1;
                            state_next      = BS_EMIT;
                        end
                        default:
                        begin
                            state_next = BS_FETCH;
                        end
                    endcase
                end
            end

            BS_FETCH:
            begin
                if (cmd_reg.op == OPC_COMPLEMENT)
                begin
                    nbr_next   = rd_data_reg & cmd_reg.nbr_mask;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = BS_SCAN;
                end
                else
                begin
                    res_row_next    = rd_data_reg;
                    res_color_next  = colors_reg[cmd_reg.vertex];
                    res_status_next = 1'b0;
                    state_next      = BS_EMIT;
                end
            end

            BS_SCAN:
            begin
                // read neighbour u now, write it back in the next cycle
                mem_we         = pend_reg;
                mem_raddr      = scan_reg;
                pend_next      = nbr_reg[scan_reg];
                pend_addr_next = scan_reg;
                scan_next      = scan_reg + VIDX_W'(1);
                if (scan_reg == VIDX_W'(MAX_VERTICES - 1))
                begin
                    state_next = BS_DRAIN;
                end
            end

            BS_DRAIN:
            begin
                mem_we          = pend_reg;
                pend_next       = 1'b0;
                colors_next     = colors_reg ^ nbr_reg[MAX_VERTICES-1:0];
                res_row_next    = nbr_reg;
                res_color_next  = colors_reg[cmd_reg.vertex];   // pivot unchanged
                res_status_next = 1'b0;
                state_next      = BS_EMIT;
            end

            BS_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    row_out_next   = res_row_reg;
                    color_out_next = res_color_reg;
                    status_next    = res_status_reg;
                    state_next     = BS_IDLE;
                end
            end

            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign row_out   = row_out_reg;
    assign color_out = color_out_reg;
    assign status    = status_reg;

endmodule

// ===== design/graph_local_complement.sv =====
// ---------------------------------------------------------------------------
// graph_local_complement - adjacency-row graph store with local complement
// Write, read and pivot complement on a graph of up to 32 vertices, each
// with a 32-bit adjacency row and a colour bit.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  config   | cfg_wr_en                 | cfg_wr_data (vertex count)
//  input    | in_valid / in_stall       | operation, vertex, row_bits, color_in
//  output   | out_valid / out_stall     | row_out, color_out, status
//
//  A complement scan walks all 32 row addresses through the single read
//  port of the row memory, one address a cycle, with the write-back of
//  each row in the following cycle.
//  Reset clears the colour bits, queue and output valid flag; the vertex
//  count returns to 32. Rows hold nothing until written.
//  The input stalls only while the two-entry command queue is full, so the
//  front end keeps taking transfers while the execution unit is busy or the
//  output is held by out_stall.
// ---------------------------------------------------------------------------
module graph_local_complement
    import glc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [VIDX_W-1:0]   vertex,
    input  logic [ROW_W-1:0]    row_bits,
    input  logic                color_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ROW_W-1:0]    row_out,
    output logic                color_out,
    output logic                status
);

    // front end -> queue
    logic       push;
    cmd_t       push_cmd;
    // queue -> execution unit
    logic       pop;
    cmd_t       head_cmd;
    q_status_t  q_status;

    // Front end: range check against min(vertex count, 32), opcode decode,
    // neighbour mask with the pivot bit already removed.
    glc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .vertex      (vertex),
        .row_bits    (row_bits),
        .color_in    (color_in),
        .q_status    (q_status),
        .push        (push),
        .cmd         (push_cmd)
    );

    // Decoupling queue; lets the front end keep taking transfers while a
    // complement scan is running.
    glc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (head_cmd),
        .q_status  (q_status)
    );

    // Execution unit: row memory, colour bits, scan sequencer, output register.
    glc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_out   (row_out),
        .color_out (color_out),
        .status    (status)
    );

endmodule

// ===== dv/glc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glc_checker - scoreboard for the graph local complement block
// Keeps its own copy of the rows, colours and vertex count, works out the
// reply to every input transfer and compares each output transfer with the
// oldest outstanding reply, field by field.
// ---------------------------------------------------------------------------
module glc_checker
    import glc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [VIDX_W-1:0]   vertex,
    input  logic [ROW_W-1:0]    row_bits,
    input  logic                color_in,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [ROW_W-1:0]    row_out,
    input  logic                color_out,
    input  logic                status,
    output int                  fail_count,
    output int                  replies_due
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             colour;
        logic             bad_vertex;
    } reply_t;

    logic [ROW_W-1:0]        adj_rows [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] colours = '0;
    logic [CNT_W-1:0]        vcount  = VCOUNT_RESET;
    reply_t                  reply_q [$];
    int                      errors  = 0;

    initial begin
        foreach (adj_rows[k])
            adj_rows[k] = '0;
    end

    // Applies one item to the graph copy and returns the reply it yields.
    function automatic reply_t apply_item(logic [OP_W-1:0]   op,
                                          logic [VIDX_W-1:0] v,
                                          logic [ROW_W-1:0]  bits,
                                          logic              col);
        int               lim;
        int               u;
        logic [ROW_W-1:0] in_range;
        logic [ROW_W-1:0] nbrs;
        reply_t           r;
        lim = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
        r   = '0;
        if (int'(v) >= lim)
        begin
            r.bad_vertex = 1'b1;
            return r;
        end
        in_range = (lim >= ROW_W) ? '1 : ((ROW_W'(1) << lim) - ROW_W'(1));
        case (op)
            OP_WRITE:
            begin
                adj_rows[v] = bits;
                colours[v]  = col;
                r.row       = bits;
                r.colour    = col;
            end
            OP_COMPLEMENT:
            begin
                // pivot is never its own neighbour; out-of-range bits ignored
                nbrs = adj_rows[v] & in_range & ~(ROW_W'(1) << v);
                for (u = 0; u < lim; u++)
                begin
                    if (nbrs[u])
                    begin
                        adj_rows[u] = adj_rows[u] ^ (nbrs & ~(ROW_W'(1) << u));
                        colours[u]  = ~colours[u];
                    end
                end
                r.row    = nbrs;
                r.colour = colours[v];
            end
            default:    // read, and the spare code which decodes as a read
            begin
                r.row    = adj_rows[v];
                r.colour = colours[v];
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [ROW_W-1:0] want,
                               logic [ROW_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            colours = '0;
            vcount  = VCOUNT_RESET;
            reply_q.delete();
        end
        else
        begin
            // results first: one arriving alongside a new input is older
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $display("%0t ns: result with none expected, %s %h %b %b",
                             $time, "expected nothing, actual",
                             row_out, color_out, status);
                    errors++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    check_field("row_out", want.row, row_out);
                    check_field("color_out", ROW_W'(want.colour), ROW_W'(color_out));
                    check_field("status", ROW_W'(want.bad_vertex), ROW_W'(status));
                end
            end
            if (in_valid && !in_stall)
                reply_q.insert(reply_q.size(),
                               apply_item(operation, vertex, row_bits, color_in));
            if (cfg_wr_en)
                vcount = cfg_wr_data;
        end
        fail_count  <= errors;
        replies_due <= reply_q.size();
    end

endmodule

// ===== dv/graph_local_complement_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// graph_local_complement_tb - top level of the graph local complement bench
// Fills every row, runs a short directed list, then random phases at a range
// of vertex counts with random idling on both channels and one long output
// hold-off per selected phase. The checker beside the block does the scoring.
// ---------------------------------------------------------------------------
module graph_local_complement_tb;
    import glc_pkg::*;

    localparam int     HALF_PERIOD     = 6;
    localparam int     SETTLE_CYCLES   = 48;      // outlasts a complement run
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     PHASE_ITEMS     = 160;
    localparam longint TIMEOUT_NS      = 64'd18_000_000;

    // spare opcode, decoded by the block as a read
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // vertex counts for the random phases: extremes, off-by-ones, above max
    localparam logic [CNT_W-1:0] PHASE_COUNTS [10] =
        '{6'd32, 6'd1, 6'd2, 6'd63, 6'd17, 6'd0, 6'd32, 6'd5, 6'd31, 6'd33};

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CNT_W-1:0]   cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [OP_W-1:0]    operation;
    logic [VIDX_W-1:0]  vertex;
    logic [ROW_W-1:0]   row_bits;
    logic               color_in;
    logic               out_valid;
    logic               out_stall;
    logic [ROW_W-1:0]   row_out;
    logic               color_out;
    logic               status;

    int fail_count;
    int replies_due;

    // stimulus-side view of the vertex count, used only to aim the vertices
    int cur_count    = MAX_VERTICES;
    // when set, neither side idles: back-to-back transfers
    bit quiet        = 1'b0;
    // long output hold-offs asked for by the stimulus, and those done
    int holds_asked  = 0;
    int holds_served = 0;

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    graph_local_complement dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .vertex      (vertex),
        .row_bits    (row_bits),
        .color_in    (color_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_out     (row_out),
        .color_out   (color_out),
        .status      (status)
    );

    glc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .vertex      (vertex),
        .row_bits    (row_bits),
        .color_in    (color_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_out     (row_out),
        .color_out   (color_out),
        .status      (status),
        .fail_count  (fail_count),
        .replies_due (replies_due)
    );

    // Idle length: mostly none or short, now and then a long one.
    // zero_pct sets how often there is no idling at all.
    function automatic int idle_cycles(int zero_pct);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Row contents: corners plus sparse, dense and uniform random patterns.
    function automatic logic [ROW_W-1:0] pick_row();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return ROW_W'(1) << $urandom_range(0, ROW_W - 1);
            3:       return $urandom & $urandom & $urandom;
            4:       return $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a vertex in range; some anywhere, so out-of-range ones turn up.
    function automatic logic [VIDX_W-1:0] pick_vertex();
        int lim;
        lim = (cur_count > MAX_VERTICES) ? MAX_VERTICES : cur_count;
        if (lim == 0 || $urandom_range(0, 99) < 15)
            return VIDX_W'($urandom_range(0, MAX_VERTICES - 1));
        return VIDX_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_WRITE;
        if (r < 65)
            return OP_COMPLEMENT;
        if (r < 95)
            return OP_READ;
        return OP_SPARE;
    endfunction

    // One input transfer, then a random gap. Valid stays high across
    // back-to-back transfers; the payload is held while stalled.
    task automatic send_item(logic [OP_W-1:0] op, logic [VIDX_W-1:0] v,
                             logic [ROW_W-1:0] bits, logic col);
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        vertex    <= v;
        row_bits  <= bits;
        color_in  <= col;
        do
            @(posedge clk);
        while (in_stall);
        gap = idle_cycles(55);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every reply is back and the block has had
    // time to finish any work still in hand.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Vertex count write, only ever with the block drained.
    task automatic set_vertex_count(logic [CNT_W-1:0] cnt);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_count    = int'(cnt);
    endtask

    // Receiver: random stalls, plus the long hold-off on request. While it
    // lasts the sender keeps offering, so the command queue fills and the
    // block has to stall its input.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served < holds_asked)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                n = idle_cycles(60);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int p;
        int i;
        int n_items;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        operation   = OP_READ;
        vertex      = '0;
        row_bits    = '0;
        color_in    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill pass: every row gets written at the reset count of 32, so no
        // later read or complement can ever touch a row that holds nothing.
        for (i = 0; i < MAX_VERTICES; i++)
            send_item(OP_WRITE, VIDX_W'(i), pick_row(), 1'($urandom_range(0, 1)));

        // Directed part, full count: row corners, first and last vertex
        send_item(OP_WRITE, 5'd0, '1, 1'b1);
        send_item(OP_WRITE, 5'd31, '0, 1'b0);
        send_item(OP_READ, 5'd0, '0, 1'b0);
        send_item(OP_READ, 5'd31, '0, 1'b0);
        send_item(OP_SPARE, 5'd0, '0, 1'b0);
        // pivot with its own bit set: self bit must be ignored
        send_item(OP_WRITE, 5'd5, 32'h8000_0026, 1'b0);
        send_item(OP_COMPLEMENT, 5'd5, '0, 1'b0);
        // every other vertex a neighbour
        send_item(OP_COMPLEMENT, 5'd0, '0, 1'b0);
        send_item(OP_READ, 5'd1, '0, 1'b0);
        send_item(OP_READ, 5'd31, '0, 1'b0);
        send_item(OP_COMPLEMENT, 5'd31, '0, 1'b0);

        // Small count: bits above the limit are kept but never neighbours
        set_vertex_count(6'd4);
        send_item(OP_WRITE, 5'd2, 32'hF000_000B, 1'b1);
        send_item(OP_COMPLEMENT, 5'd2, '0, 1'b0);
        send_item(OP_READ, 5'd2, '0, 1'b0);
        send_item(OP_READ, 5'd0, '0, 1'b0);
        send_item(OP_WRITE, 5'd4, '1, 1'b1);
        send_item(OP_COMPLEMENT, 5'd7, '0, 1'b0);
        send_item(OP_READ, 5'd31, '0, 1'b0);

        // Count zero: every vertex out of range
        set_vertex_count(6'd0);
        send_item(OP_READ, 5'd0, '0, 1'b0);
        send_item(OP_WRITE, 5'd0, '1, 1'b1);
        send_item(OP_COMPLEMENT, 5'd0, '0, 1'b0);

        // Random phases, one per vertex count
        for (p = 0; p < $size(PHASE_COUNTS); p++)
        begin
            set_vertex_count(PHASE_COUNTS[p]);
            n_items = (PHASE_COUNTS[p] == 0) ? 40 : PHASE_ITEMS;
            for (i = 0; i < n_items; i++)
            begin
                if (i % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if (i == 40 && (p == 0 || p == 6))
                    holds_asked++;
                send_item(pick_op(), pick_vertex(), pick_row(),
                          1'($urandom_range(0, 1)));
            end
        end

        quiet = 1'b0;
        drain();
        if (fail_count == 0 && replies_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/glc_pkg.sv
design/glc_front.sv
design/glc_queue.sv
design/glc_back.sv
design/graph_local_complement.sv
dv/glc_checker.sv
dv/graph_local_complement_tb.sv
